[sv/scan_obstacle_run_detector_macros.svh]
// Assertion helpers used by the detector back end (sord_back).
`ifndef SCAN_OBSTACLE_RUN_DETECTOR_MACROS_SVH
`define SCAN_OBSTACLE_RUN_DETECTOR_MACROS_SVH

// Condition must hold at every edge outside reset.
`define SORD_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SORD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/sord_pkg.sv]
package sord_pkg;

    localparam int STEP_W     = 10;
    localparam int DIST_W     = 16;
    localparam int RUN_W      = 5;
    localparam int RUN_IDX_W  = 4;
    localparam int TALLY_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int M_TDATA_W  = 48;
    localparam int EVT_W      = STEP_W + DIST_W + 1 + TALLY_W;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    localparam logic [RUN_W-1:0]   MAX_RUN   = 5'd16;
    localparam logic [STEP_W-1:0]  LAST_STEP = 10'd1023;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 16'hFFFF;

    localparam logic [DIST_W-1:0] THRESHOLD_RST = 16'd1000;
    localparam logic [STEP_W-1:0] WIN_START_RST = 10'd0;
    localparam logic [STEP_W-1:0] WIN_END_RST   = 10'd681;
    localparam logic [RUN_W-1:0]  MIN_RUN_RST   = 5'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIN_START = 2'd1,
        CFG_WIN_END   = 2'd2,
        CFG_MIN_RUN   = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        EV_OBSTACLE = 1'b0,
        EV_CLEAR    = 1'b1
    } ev_kind_t;

    // One queued command expands into last_idx+1 events.
    typedef struct packed {
        ev_kind_t                 kind;
        logic [STEP_W-1:0]        first_step;
        logic [RUN_IDX_W-1:0]     last_idx;
        logic [DIST_W-1:0]        distance;
        logic                     whole;
        logic [TALLY_W-1:0]       tally;
    } cmd_t;

endpackage

[sv/sord_front.sv]
module sord_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [sord_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sord_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic [sord_pkg::DIST_W-1:0]     s_tdata,
    input  logic                            s_tlast,
    output logic                            s_tready,
    input  logic                            q_full,
    output logic                            push,
    output sord_pkg::cmd_t                  cmd
);
    import sord_pkg::*;

    logic [DIST_W-1:0]  threshold_reg;
    logic [STEP_W-1:0]  win_start_reg;
    logic [STEP_W-1:0]  win_end_reg;
    logic [RUN_W-1:0]   min_run_reg;

    logic [STEP_W-1:0]  step_reg, step_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic               active_reg, active_next;
    logic               from_start_reg, from_start_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;

    logic               accept;
    logic               in_win;
    logic               is_close;
    logic [RUN_W-1:0]   need;
    logic [RUN_W-1:0]   run_inc;
    logic [STEP_W-1:0]  first;
    logic               burst;
    logic               single;
    logic               clear_ev;
    logic               wrap;
    logic               burst_from_start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            win_start_reg <= WIN_START_RST;
            win_end_reg   <= WIN_END_RST;
            min_run_reg   <= MIN_RUN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_WIN_START: win_start_reg <= cfg_data[STEP_W-1:0];
                CFG_WIN_END:   win_end_reg   <= cfg_data[STEP_W-1:0];
                CFG_MIN_RUN:   min_run_reg   <= cfg_data[RUN_W-1:0];
            endcase
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        priority if (min_run_reg == '0) begin
            need = RUN_W'(1);
        end else if (min_run_reg > MAX_RUN) begin
            need = MAX_RUN;
        end else begin
            need = min_run_reg;
        end
    end

    assign in_win   = (step_reg >= win_start_reg) && (step_reg <= win_end_reg);
    assign is_close = (s_tdata != '0) && (s_tdata < threshold_reg);
    assign run_inc  = (run_reg <= need) ? run_reg + RUN_W'(1) : run_reg;
    assign first    = step_reg + STEP_W'(1) - STEP_W'(need);
    assign burst    = in_win && is_close && (run_inc == need);
    assign single   = in_win && is_close && (run_inc > need);
    assign clear_ev = in_win && !is_close && active_reg;
    assign wrap     = s_tlast || (step_reg == LAST_STEP);
    assign burst_from_start = (first == win_start_reg);

    always_comb begin
        step_next       = step_reg;
        run_next        = run_reg;
        active_next     = active_reg;
        from_start_next = from_start_reg;
        tally_next      = tally_reg;
        if (accept) begin
            if (in_win) begin
                if (is_close) begin
                    run_next = run_inc;
                    if (burst) begin
                        active_next     = 1'b1;
                        from_start_next = burst_from_start;
                        if (tally_reg != TALLY_MAX) begin
                            tally_next = tally_reg + TALLY_W'(1);
                        end
                    end else if (single) begin
                        active_next = 1'b1;
                    end
                end else begin
                    active_next     = 1'b0;
                    run_next        = '0;
                    from_start_next = 1'b0;
                end
            end
            if (wrap) begin
                step_next       = '0;
                run_next        = '0;
                from_start_next = 1'b0;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= '0;
            run_reg        <= '0;
            active_reg     <= 1'b0;
            from_start_reg <= 1'b0;
            tally_reg      <= '0;
        end else begin
            step_reg       <= step_next;
            run_reg        <= run_next;
            active_reg     <= active_next;
            from_start_reg <= from_start_next;
            tally_reg      <= tally_next;
        end
    end

    assign push = accept && (burst || single || clear_ev);

    always_comb begin
        cmd.kind       = clear_ev ? EV_CLEAR : EV_OBSTACLE;
        cmd.first_step = burst ? first : step_reg;
        cmd.last_idx   = burst ? RUN_IDX_W'(need - RUN_W'(1)) : '0;
        cmd.distance   = s_tdata;
        cmd.tally      = tally_next;
        if (burst) begin
            cmd.whole = (step_reg == win_end_reg) && burst_from_start;
        end else if (single) begin
            cmd.whole = (step_reg == win_end_reg) && from_start_reg;
        end else begin
            cmd.whole = 1'b0;
        end
    end

endmodule

[sv/sord_fifo.sv]
module sord_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sord_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output sord_pkg::cmd_t head
);
    import sord_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[sv/sord_back.sv]
`include "scan_obstacle_run_detector_macros.svh"

module sord_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_not_empty,
    input  sord_pkg::cmd_t                 head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sord_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import sord_pkg::*;

    logic [RUN_IDX_W-1:0] idx_reg;
    logic                 valid_reg;
    ev_kind_t             kind_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic                 whole_reg;
    logic [TALLY_W-1:0]   tally_reg;
    logic                 last_reg;

    logic load;
    logic final_beat;

    // Load a new beat when the output slot is empty or being drained.
    assign load       = q_not_empty && (!valid_reg || m_tready);
    assign final_beat = (idx_reg == head.last_idx);
    assign pop        = load && final_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg <= final_beat ? '0 : idx_reg + RUN_IDX_W'(1);
            end
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= head.kind;
            step_reg  <= head.first_step + STEP_W'(idx_reg);
            dist_reg  <= head.distance;
            whole_reg <= head.whole && final_beat;
            tally_reg <= head.tally;
            last_reg  <= final_beat;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(M_TDATA_W - EVT_W)'(0), tally_reg, whole_reg, dist_reg, step_reg};

    `SORD_ASSERT_IMPLIES(a_idx_in_cmd, q_not_empty, idx_reg <= head.last_idx,
        "burst index beyond command length")
    `SORD_ASSERT_IMPLIES(a_mid_burst_held, idx_reg != '0, q_not_empty,
        "burst in progress without a queued command")
    `SORD_ASSERT_IMPLIES(a_whole_on_obstacle, valid_reg && whole_reg,
        kind_reg == EV_OBSTACLE && last_reg, "whole_window on a non-final or clear beat")
    `SORD_ASSERT_IMPLIES(a_clear_single, valid_reg && kind_reg == EV_CLEAR, last_reg,
        "clear event not marked last")

endmodule

[sv/scan_obstacle_run_detector.sv]
// Obstacle run detector for lidar range samples delivered in scan order.
// Input stream: one beat per sample; s_tdata carries the range in mm, s_tlast
// marks the last sample of a scan. The step counter also wraps after step 1023.
// Config channel: cfg_index selects threshold_mm, window_start, window_end or
// min_run; cfg_ready is always high, write only while the block is idle.
// Output stream: one beat per event. An accepted sample yields no beat, one
// obstacle or clear beat, or a confirmation burst of min_run beats (min_run
// clamped to 1..16); m_tlast flags the final beat that a sample produced.
// Path: an accepted sample's command enters the queue at the accepting edge,
// and its beats then pass from the queue head through the output register.
// Flow: the front classifies one sample per cycle, while the queue has room,
// into a four-entry command queue; the back drains one beat per cycle while
// m_tready is high, so the front can accept new samples while bursts drain.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// step counter, run, obstacle flag and tally, and empties the queue.
// A stalled m_tready holds the current beat; the queue then fills and
// s_tready drops until the back frees a slot.
module scan_obstacle_run_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sord_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sord_pkg::CFG_DATA_W-1:0] cfg_data,
    // sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sord_pkg::DIST_W-1:0]     s_tdata,   // [15:0] distance_mm
    input  logic                            s_tlast,   // end_of_scan
    // event stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [9:0] step_index, [25:10] event_distance, [26] whole_window,
    // [42:27] obstacle_total, [47:43] zero
    output logic [sord_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser,   // [0] event_kind
    output logic                            m_tlast    // last
);
    import sord_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_in;
    cmd_t q_head;

    assign cfg_ready = 1'b1;

    // Front: config registers, step/run tracking, one command per event source.
    sord_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (q_in)
    );

    // Queue decouples sample intake from burst expansion.
    sord_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Back: expand each command into beats through the output register.
    sord_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .head        (q_head),
        .pop         (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
